@@ sv/permutation_check_and_parity_core_macros.svh @@
// ----------------------------------------------------------------------------
// Permutation check and parity: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_CHECK_AND_PARITY_CORE_MACROS_SVH
`define PERMUTATION_CHECK_AND_PARITY_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define PCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Permutation check and parity: package
// Sizes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pcp_pkg;

   localparam int MAX_N   = 64;
   localparam int IDX_W   = $clog2(MAX_N);
   localparam int CNT_W   = $clog2(MAX_N + 1);
   localparam int VALUE_W = 8;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic load;         // store the accepted request
      logic start_cycle;  // open a new cycle at position j
      logic follow;       // read along the cycle from the last read value
      logic advance_j;    // move to the next position
      logic capture;      // load the result register
      logic clear_set;    // drop all per-set state
   } cmd_type;

   typedef struct packed {
      logic set_ok;
      logic scan_done;
      logic j_visited;
      logic cycle_closed;
   } status_type;

endpackage

@@ sv/pcp_if.sv @@
// ----------------------------------------------------------------------------
// Permutation check and parity: channel interfaces
// Request channel (entries) and response channel (set result).
// ----------------------------------------------------------------------------
interface pcp_req_if import pcp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] entry_value;
   logic               last_entry;

   modport source (output valid, entry_value, last_entry, input ready);
   modport sink   (input valid, entry_value, last_entry, output ready);
endinterface

interface pcp_rsp_if import pcp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               is_valid;
   logic               is_odd;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, is_valid, is_odd, entry_count, input ready);
   modport sink   (input valid, is_valid, is_odd, entry_count, output ready);
endinterface

@@ sv/pcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Permutation check and parity: controller
// Sequences loading, evaluation, the cycle walk and the response handoff.
// ----------------------------------------------------------------------------
module pcp_ctrl import pcp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EVAL,
      ST_SCAN,
      ST_FOLLOW,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            state_in = status.set_ok ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            priority if (status.scan_done) begin
               state_in = ST_FINISH;
            end else if (status.j_visited) begin
               cmd.advance_j = 1'b1;
            end else begin
               cmd.start_cycle = 1'b1;
               state_in        = ST_FOLLOW;
            end
         end
         ST_FOLLOW: begin
            cmd.follow = 1'b1;
            if (status.cycle_closed) begin
               cmd.advance_j = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_FINISH: begin
            // wait for the result register to drain
            if (slot_free) begin
               cmd.capture   = 1'b1;
               cmd.clear_set = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/pcp_datapath.sv @@
// ----------------------------------------------------------------------------
// Permutation check and parity: datapath
// Entry memory, seen and visited maps, set flags, walk state, result register.
// ----------------------------------------------------------------------------
module pcp_datapath import pcp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [VALUE_W-1:0] entry_value,
   output status_type         status,
   output logic               is_valid,
   output logic               is_odd,
   output logic [COUNT_W-1:0] entry_count
);

   logic [IDX_W-1:0] perm_mem [MAX_N];
   logic [IDX_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   logic [MAX_N-1:0] seen_ff;
   logic [MAX_N-1:0] visited_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] j_ff;
   logic [IDX_W-1:0] max_ff;
   logic             range_err_ff;
   logic             dup_ff;
   logic             cyc_par_ff;

   logic               is_valid_ff;
   logic               is_odd_ff;
   logic [COUNT_W-1:0] entry_count_ff;

   logic [IDX_W-1:0] value_idx;
   logic [IDX_W-1:0] j_idx;
   logic             value_big;
   logic             set_full;
   logic             set_ok;

   assign value_idx = IDX_W'(entry_value);
   assign j_idx     = j_ff[IDX_W-1:0];
   assign value_big = (int'(entry_value) >= MAX_N);
   assign set_full  = (fill_ff == CNT_W'(MAX_N));

   // n distinct values, all below n, make a permutation
   assign set_ok = !range_err_ff && !dup_ff && (CNT_W'(max_ff) < fill_ff);

   assign status.set_ok       = set_ok;
   assign status.scan_done    = (j_ff == fill_ff);
   assign status.j_visited    = visited_ff[j_idx];
   assign status.cycle_closed = (rd_data_ff == j_idx);

   assign rd_addr = cmd.follow ? rd_data_ff : j_idx;

   always_ff @(posedge clock) begin
      if (cmd.load && !set_full && !value_big) begin
         perm_mem[fill_ff[IDX_W-1:0]] <= value_idx;
      end
      rd_data_ff <= perm_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_set) begin
         seen_ff      <= '0;
         visited_ff   <= '0;
         fill_ff      <= '0;
         j_ff         <= '0;
         max_ff       <= '0;
         range_err_ff <= 1'b0;
         dup_ff       <= 1'b0;
         cyc_par_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (set_full) begin
               range_err_ff <= 1'b1;
            end else begin
               fill_ff <= fill_ff + CNT_W'(1);
               if (value_big) begin
                  range_err_ff <= 1'b1;
               end else begin
                  if (seen_ff[value_idx]) begin
                     dup_ff <= 1'b1;
                  end
                  seen_ff[value_idx] <= 1'b1;
                  if (value_idx > max_ff) begin
                     max_ff <= value_idx;
                  end
               end
            end
         end
         if (cmd.start_cycle) begin
            cyc_par_ff <= !cyc_par_ff;
         end
         if (cmd.follow) begin
            visited_ff[rd_data_ff] <= 1'b1;
         end
         if (cmd.advance_j) begin
            j_ff <= j_ff + CNT_W'(1);
         end
      end
   end

   // parity of n minus the number of orbits of the permutation
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_valid_ff    <= set_ok;
         is_odd_ff      <= set_ok && (fill_ff[0] ^ cyc_par_ff);
         entry_count_ff <= COUNT_W'(fill_ff);
      end
   end

   assign is_valid    = is_valid_ff;
   assign is_odd      = is_odd_ff;
   assign entry_count = entry_count_ff;

endmodule

@@ sv/permutation_check_and_parity_core.sv @@
// Entries load at one per cycle in the load state; the last entry is followed
// by an evaluation step, a cycle walk for a valid permutation only (one scan
// step and one memory read per position, plus the closing scan step), then a
// capture into the response register once it is free. The walk uses the single
// read port of the entry memory. Entries of the next set are taken only after
// the capture, also while a response waits. Synchronous reset empties the set.
// ----------------------------------------------------------------------------
// Permutation check and parity: top level
// Checks that a set of entries is a permutation and reports its parity.
// ----------------------------------------------------------------------------
module permutation_check_and_parity_core import pcp_pkg::*; (
   input logic       clock,
   input logic       reset,
   pcp_req_if.sink   req_ch,
   pcp_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   pcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_entry),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .entry_value (req_ch.entry_value),
      .status      (status),
      .is_valid    (rsp_ch.is_valid),
      .is_odd      (rsp_ch.is_odd),
      .entry_count (rsp_ch.entry_count)
   );

endmodule

@@ sv/pcp_checker.sv @@
// ----------------------------------------------------------------------------
// Permutation check and parity: port checker
// Watches the response channel of the top level over time.
// ----------------------------------------------------------------------------
`include "permutation_check_and_parity_core_macros.svh"

module pcp_checker import pcp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_is_valid,
   input logic               rsp_is_odd,
   input logic [COUNT_W-1:0] rsp_entry_count
);

   `PCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_is_valid, rsp_is_odd, rsp_entry_count}), "response dropped or changed while stalled")
   `PCP_ASSERT_NOW(a_odd_needs_valid, clock, reset, rsp_valid && rsp_is_odd, rsp_is_valid, "odd parity on an invalid set")
   `PCP_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, rsp_entry_count != 0 && 32'(rsp_entry_count) <= MAX_N, "entry count out of range")
   `PCP_ASSERT_NOW(a_single_even, clock, reset, rsp_valid && rsp_is_valid && rsp_entry_count == 1, !rsp_is_odd, "single entry reported odd")

endmodule

bind permutation_check_and_parity_core pcp_checker u_pcp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_is_valid    (rsp_ch.is_valid),
   .rsp_is_odd      (rsp_ch.is_odd),
   .rsp_entry_count (rsp_ch.entry_count)
);
